[sv/teq_pkg.sv]
package teq_pkg;

   localparam int TIME_W   = 64;
   localparam int BUDGET_W = 32;
   localparam int ETYPE_W  = 4;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_RESCHED  = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_ADVANCE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_INS_PREP,
      S_INS,
      S_INS_HEAD,
      S_ADV,
      S_HEAD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                fired;
      logic [ETYPE_W-1:0]  fired_type;
      logic                preempt;
      logic [BUDGET_W-1:0] budget;
      logic                queue_empty;
      logic [TIME_W-1:0]   now;
      status_type          status;
   } result_type;

endpackage

[sv/teq_ram.sv]
module teq_ram #(
   parameter int WIDTH = 68,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/teq_ctrl.sv]
module teq_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TYPE_BITS   = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_opcode,
   input  logic [3:0]                             req_event_type,
   input  logic [31:0]                            req_delay,
   input  logic [31:0]                            req_elapsed,
   input  logic                                   rsp_free,
   output logic                                   done,
   output teq_pkg::result_type                    result,
   output logic                                   wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]         wr_addr,
   output logic [teq_pkg::TIME_W+TYPE_BITS-1:0]   wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0]         rd_addr,
   input  logic [teq_pkg::TIME_W+TYPE_BITS-1:0]   rd_data
);
   import teq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TB = TYPE_BITS;

   state_type         state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [TB-1:0]     type_ff, type_in;
   logic [31:0]       delay_ff, delay_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] cycle_ff, cycle_in;
   logic [TIME_W-1:0] when_ff, when_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              ph_ff, ph_in;
   logic              found_ff, found_in;
   logic              pre_ff, pre_in;
   logic              fired_ff, fired_in;
   logic [TB-1:0]     ftype_ff, ftype_in;
   status_type        status_ff, status_in;
   logic [31:0]       budget_ff, budget_in;

   logic [TB+3:0]     req_type_ext;
   logic [TB+3:0]     ftype_ext;
   logic [TIME_W-1:0] rd_time;
   logic [TB-1:0]     rd_type;
   logic [TIME_W-1:0] diff;
   logic              hit;
   logic              last;
   logic              head_due;
   logic              ins_before;

   assign req_type_ext = {{TB{1'b0}}, req_event_type};
   assign ftype_ext    = {4'b0000, ftype_ff};
   assign rd_time      = rd_data[TB+TIME_W-1:TB];
   assign rd_type      = rd_data[TB-1:0];
   assign diff         = rd_time - cycle_ff;
   assign hit          = !found_ff && (rd_type == type_ff);
   assign last         = (CW'(idx_ff) == count_ff - 1'b1);
   assign head_due     = (cycle_ff >= rd_time);
   assign ins_before   = (when_ff < rd_time);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (opcode_type'(req_opcode))
                  OP_ADD: begin
                     state_in = (count_ff == CW'(QUEUE_DEPTH)) ? S_HEAD : S_INS_PREP;
                  end
                  OP_RESCHED, OP_REMOVE: begin
                     state_in = (count_ff == '0) ? S_HEAD : S_FIND;
                  end
                  OP_ADVANCE: begin
                     state_in = (count_ff == '0) ? S_HEAD : S_ADV;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (ph_ff && last) begin
               if ((found_ff || hit) && op_ff == OP_RESCHED) begin
                  state_in = S_INS_PREP;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_INS_PREP: begin
            state_in = (count_ff == '0) ? S_INS_HEAD : S_INS;
         end
         S_INS: begin
            if (ph_ff) begin
               if (!ins_before) begin
                  state_in = S_HEAD;
               end else if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end
            end
         end
         S_INS_HEAD: state_in = S_HEAD;
         S_ADV: begin
            if (ph_ff) begin
               if (head_due && count_ff != CW'(1)) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (ph_ff || count_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in      = op_ff;
      type_in    = type_ff;
      delay_in   = delay_ff;
      elapsed_in = elapsed_ff;
      cycle_in   = cycle_ff;
      when_in    = when_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ph_in      = ph_ff;
      found_in   = found_ff;
      pre_in     = pre_ff;
      fired_in   = fired_ff;
      ftype_in   = ftype_ff;
      status_in  = status_ff;
      budget_in  = budget_ff;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      done       = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = opcode_type'(req_opcode);
               type_in    = req_type_ext[TB-1:0];
               delay_in   = req_delay;
               elapsed_in = req_elapsed;
               fired_in   = 1'b0;
               ftype_in   = '0;
               pre_in     = 1'b0;
               found_in   = 1'b0;
               status_in  = ST_OK;
               idx_in     = '0;
               ph_in      = 1'b0;
               unique case (opcode_type'(req_opcode))
                  OP_ADD: begin
                     cycle_in = cycle_ff + TIME_W'(req_elapsed);
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_RESCHED, OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOTFOUND;
                     end
                  end
                  OP_ADVANCE: begin
                     cycle_in = cycle_ff + TIME_W'(req_elapsed);
                  end
                  default: ;
               endcase
            end
         end
         S_FIND: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (hit) begin
                  found_in = 1'b1;
                  if (idx_ff == '0 && op_ff == OP_REMOVE) begin
                     pre_in = 1'b1;
                  end
               end
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - 1'b1;
               end
               if (last) begin
                  if (found_ff || hit) begin
                     count_in = count_ff - 1'b1;
                     if (op_ff == OP_RESCHED) begin
                        cycle_in = cycle_ff + TIME_W'(elapsed_ff);
                     end
                  end else begin
                     status_in = ST_NOTFOUND;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_INS_PREP: begin
            when_in = cycle_ff + TIME_W'(delay_ff);
            idx_in  = IW'(count_ff - 1'b1);
            ph_in   = 1'b0;
         end
         S_INS: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff + 1'b1;
               if (ins_before) begin
                  idx_in = idx_ff - 1'b1;
               end else begin
                  wr_data  = {when_ff, type_ff};
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_INS_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {when_ff, type_ff};
            pre_in   = (count_ff != '0);
            count_in = count_ff + 1'b1;
            ph_in    = 1'b0;
         end
         S_ADV: begin
            ph_in   = !ph_ff;
            rd_addr = '0;
            if (ph_ff && head_due) begin
               fired_in = 1'b1;
               ftype_in = rd_type;
               cycle_in = rd_time;
               if (count_ff == CW'(1)) begin
                  count_in = '0;
               end else begin
                  idx_in   = IW'(1);
                  found_in = 1'b1;
               end
            end
         end
         S_HEAD: begin
            rd_addr = '0;
            if (count_ff == '0) begin
               budget_in = '1;
               ph_in     = 1'b0;
            end else begin
               ph_in = !ph_ff;
               if (ph_ff) begin
                  if (rd_time > cycle_ff) begin
                     budget_in = (diff[TIME_W-1:32] != '0) ? '1 : diff[31:0];
                  end else begin
                     budget_in = '0;
                  end
               end
            end
         end
         S_DONE: begin
            done = rsp_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cycle_ff <= '0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cycle_ff <= cycle_in;
         ph_ff    <= ph_in;
      end
      op_ff      <= op_in;
      type_ff    <= type_in;
      delay_ff   <= delay_in;
      elapsed_ff <= elapsed_in;
      when_ff    <= when_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      pre_ff     <= pre_in;
      fired_ff   <= fired_in;
      ftype_ff   <= ftype_in;
      status_ff  <= status_in;
      budget_ff  <= budget_in;
   end

   assign result.fired       = fired_ff;
   assign result.fired_type  = ftype_ext[3:0];
   assign result.preempt     = pre_ff;
   assign result.budget      = budget_ff;
   assign result.queue_empty = (count_ff == '0);
   assign result.now         = cycle_ff;
   assign result.status      = status_ff;

endmodule

[sv/timed_event_queue_unit.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   opcode, event_type, delay, elapsed
// rsp      out        rsp_valid/rsp_ready   fired, fired_type, preempt, budget,
//                                           queue_empty, now, status
//
// One request at a time; the entry memory has one read and one write port and
// each entry visited is read, then compared and written back.
// A reschedule walks the queue twice when its entry is found.
// Reset clears the entry count and the clock; the memory itself is not cleared.
// A new request is taken while the previous response still waits for rsp_ready.
module timed_event_queue_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TYPE_BITS   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_event_type,
   input  logic [31:0] req_delay,
   input  logic [31:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fired,
   output logic [3:0]  rsp_fired_type,
   output logic        rsp_preempt,
   output logic [31:0] rsp_budget,
   output logic        rsp_queue_empty,
   output logic [63:0] rsp_now,
   output logic [1:0]  rsp_status
);
   import teq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int EW = TIME_W + TYPE_BITS;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          done;
   logic          rsp_free;
   result_type    result;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   teq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   teq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TYPE_BITS   (TYPE_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_event_type (req_event_type),
      .req_delay      (req_delay),
      .req_elapsed    (req_elapsed),
      .rsp_free       (rsp_free),
      .done           (done),
      .result         (result),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = rsp_ff.fired;
   assign rsp_fired_type  = rsp_ff.fired_type;
   assign rsp_preempt     = rsp_ff.preempt;
   assign rsp_budget      = rsp_ff.budget;
   assign rsp_queue_empty = rsp_ff.queue_empty;
   assign rsp_now         = rsp_ff.now;
   assign rsp_status      = rsp_ff.status;

endmodule

[sim/timed_event_queue_unit_tb.sv]
`timescale 1ns / 1ps

module timed_event_queue_unit_tb;
   import teq_pkg::*;

   typedef struct {
      opcode_type  op;
      logic [3:0]  etype;
      logic [31:0] delay;
      logic [31:0] elapsed;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_event_type = '0;
   logic [31:0] req_delay = '0;
   logic [31:0] req_elapsed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_fired;
   logic [3:0]  rsp_fired_type;
   logic        rsp_preempt;
   logic [31:0] rsp_budget;
   logic        rsp_queue_empty;
   logic [63:0] rsp_now;
   logic [1:0]  rsp_status;

   request_type pending_requests[$];
   result_type  expected_results[$];

   logic [63:0] sched_time[16];
   logic [3:0]  sched_type[16];
   int          sched_count;
   logic [63:0] sched_clock;

   int send_idle_pct = 23;
   int recv_idle_pct = 47;
   int mismatches    = 0;
   int responses     = 0;
   int fired_count   = 0;
   int full_count    = 0;
   int missing_count = 0;
   int sent_count    = 0;

   timed_event_queue_unit u_top (.*);

   always #5 clock = ~clock;

   function automatic int find_event(logic [3:0] t);
      for (int i = 0; i < sched_count; i++) begin
         if (sched_type[i] == t) return i;
      end
      return -1;
   endfunction

   function automatic void drop_event(int pos);
      for (int i = pos; i + 1 < sched_count; i++) begin
         sched_time[i] = sched_time[i + 1];
         sched_type[i] = sched_type[i + 1];
      end
      sched_count--;
   endfunction

   function automatic status_type insert_event(logic [3:0] t, logic [31:0] d,
                                               logic [31:0] e, ref logic pre);
      logic [63:0] when;
      int pos;
      sched_clock = sched_clock + 64'(e);
      if (sched_count >= 16) return ST_FULL;
      when = sched_clock + 64'(d);
      pos = sched_count;
      for (int i = 0; i < sched_count; i++) begin
         if (when < sched_time[i]) begin
            pos = i;
            break;
         end
      end
      for (int i = sched_count; i > pos; i--) begin
         sched_time[i] = sched_time[i - 1];
         sched_type[i] = sched_type[i - 1];
      end
      sched_time[pos] = when;
      sched_type[pos] = t;
      if (pos == 0 && sched_count > 0) pre = 1'b1;
      sched_count++;
      return ST_OK;
   endfunction

   function automatic result_type schedule_step(request_type r);
      result_type res;
      logic pre;
      int pos;
      logic [63:0] gap;
      res = '0;
      pre = 1'b0;
      res.status = ST_OK;
      case (r.op)
         OP_ADD: begin
            res.status = insert_event(r.etype, r.delay, r.elapsed, pre);
         end
         OP_RESCHED: begin
            pos = find_event(r.etype);
            if (pos < 0) begin
               res.status = ST_NOTFOUND;
            end else begin
               drop_event(pos);
               res.status = insert_event(r.etype, r.delay, r.elapsed, pre);
            end
         end
         OP_REMOVE: begin
            pos = find_event(r.etype);
            if (pos < 0) begin
               res.status = ST_NOTFOUND;
            end else begin
               if (pos == 0) pre = 1'b1;
               drop_event(pos);
            end
         end
         default: begin
            sched_clock = sched_clock + 64'(r.elapsed);
            if (sched_count > 0 && sched_clock >= sched_time[0]) begin
               res.fired = 1'b1;
               res.fired_type = sched_type[0];
               sched_clock = sched_time[0];
               drop_event(0);
            end
         end
      endcase
      if (sched_count == 0) begin
         res.budget = '1;
      end else if (sched_time[0] > sched_clock) begin
         gap = sched_time[0] - sched_clock;
         res.budget = (gap > 64'hFFFF_FFFF) ? '1 : gap[31:0];
      end else begin
         res.budget = '0;
      end
      res.preempt = pre;
      res.queue_empty = (sched_count == 0);
      res.now = sched_clock;
      return res;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(0, 20));
         3: return 32'($urandom_range(0, 2000));
         default: return $urandom();
      endcase
   endfunction

   task automatic push_request(opcode_type op, logic [3:0] t, logic [31:0] d,
                               logic [31:0] e);
      request_type r;
      r.op = op;
      r.etype = t;
      r.delay = d;
      r.elapsed = e;
      pending_requests.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) sent_count++;
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_results.push_back(schedule_step(r));
            req_valid      <= 1'b1;
            req_opcode     <= r.op;
            req_event_type <= r.etype;
            req_delay      <= r.delay;
            req_elapsed    <= r.elapsed;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_type exp;
            responses++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response with none expected at %0t", $realtime);
            end else begin
               exp = expected_results.pop_front();
               if (exp.fired) fired_count++;
               if (exp.status == ST_FULL) full_count++;
               if (exp.status == ST_NOTFOUND) missing_count++;
               if (rsp_fired !== exp.fired || rsp_fired_type !== exp.fired_type ||
                   rsp_preempt !== exp.preempt || rsp_budget !== exp.budget ||
                   rsp_queue_empty !== exp.queue_empty || rsp_now !== exp.now ||
                   rsp_status !== exp.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected f=%0b t=%0d p=%0b b=%0h e=%0b n=%0h s=%0d",
                              exp.fired, exp.fired_type, exp.preempt, exp.budget,
                              exp.queue_empty, exp.now, exp.status);
                     $display("          actual   f=%0b t=%0d p=%0b b=%0h e=%0b n=%0h s=%0d",
                              rsp_fired, rsp_fired_type, rsp_preempt, rsp_budget,
                              rsp_queue_empty, rsp_now, rsp_status);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      sched_count = 0;
      sched_clock = '0;
      for (int i = 0; i < 16; i++) begin
         sched_time[i] = '0;
         sched_type[i] = '0;
      end
      // Directed: empty-queue cases, extremes, overflow of the queue.
      push_request(OP_ADVANCE, 4'd0, 32'd0, 32'd5);
      push_request(OP_REMOVE, 4'd3, 32'd0, 32'd0);
      push_request(OP_RESCHED, 4'd3, 32'd9, 32'd7);
      push_request(OP_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_request(OP_ADD, 4'd1, 32'd10, 32'd0);
      push_request(OP_ADD, 4'd2, 32'd10, 32'd0);
      push_request(OP_RESCHED, 4'd1, 32'd0, 32'd1);
      push_request(OP_REMOVE, 4'd1, 32'd0, 32'd0);
      push_request(OP_REMOVE, 4'd15, 32'd0, 32'd0);
      push_request(OP_ADVANCE, 4'd0, 32'd0, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++) push_request(OP_ADD, 4'(i), 32'(i * 3), 32'd0);
      push_request(OP_RESCHED, 4'd5, 32'd0, 32'd0);
      push_request(OP_ADVANCE, 4'd0, 32'd0, 32'd0);
      push_request(OP_ADVANCE, 4'd0, 32'd0, 32'd100);
      // Random part, mostly adds and advances with reschedules and removes mixed in.
      for (int i = 0; i < 1650; i++) begin
         int sel;
         sel = $urandom_range(0, 9);
         push_request(sel < 4 ? OP_ADD : sel < 5 ? OP_RESCHED : sel < 6 ? OP_REMOVE : OP_ADVANCE,
                      4'($urandom()), rand_word(), rand_word());
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_requests.size() < 1100);
      send_idle_pct = 47;
      recv_idle_pct = 23;
      wait (pending_requests.size() < 550);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (80) @(posedge clock);
      $display("%0d requests, %0d responses: %0d fired, %0d full, %0d not found",
               sent_count, responses, fired_count, full_count, missing_count);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("timed_event_queue_unit: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("timed_event_queue_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("timed_event_queue_unit: mismatch");
      $finish;
   end

endmodule
